@@ rtl/sxe_pkg.sv @@
package sxe_pkg;

  // Field widths of the channels.
  localparam int PixW      = 8;
  localparam int CfgDataW  = 11;
  localparam int CfgIndexW = 2;

  // Default line store depth and the frame height limit.
  localparam int MaxWidthDflt = 1024;
  localparam int HeightCap    = 1024;

  // Register values after reset.
  localparam logic [CfgDataW-1:0] WidthRst  = CfgDataW'(640);
  localparam logic [CfgDataW-1:0] HeightRst = CfgDataW'(480);

  typedef enum logic [CfgIndexW-1:0] {
    RegFrameWidth  = 2'd0,
    RegFrameHeight = 2'd1
  } sxe_reg_e;

  // One line store entry: the pixel two rows up and the pixel one row up.
  typedef struct packed {
    logic [PixW-1:0] prev;
    logic [PixW-1:0] curr;
  } line_word_t;

endpackage

@@ rtl/sxe_stream_if.sv @@
interface sxe_pix_if;
  import sxe_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_in;
  logic            trailer;

  modport source (output valid, pixel_in, trailer, input ready);
  modport sink (input valid, pixel_in, trailer, output ready);
endinterface

interface sxe_res_if;
  import sxe_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] edge_value;
  logic            frame_last;

  modport source (output valid, edge_value, frame_last, input ready);
  modport sink (input valid, edge_value, frame_last, output ready);
endinterface

interface sxe_cfg_if;
  import sxe_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/sxe_line_mem.sv @@
module sxe_line_mem #(
  parameter int Depth = sxe_pkg::MaxWidthDflt,
  localparam int AW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [AW-1:0]       rd_addr_i,
  output sxe_pkg::line_word_t rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  sxe_pkg::line_word_t wr_data_i,
  output logic                clr_busy_o
);
  import sxe_pkg::*;

  line_word_t    line_mem [Depth];
  line_word_t    rd_data_q;
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // After reset every entry is swept to zero, one per cycle.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(Depth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The read returns the entry as it was before a write in the same cycle.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      line_mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      line_mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= line_mem[rd_addr_i];
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

@@ rtl/sobel_x_edge_filter.sv @@
// Horizontal-gradient Sobel filter for a stream of 8-bit grey pixels.
//
// Pixels enter on pix_i in raster order, one item per pixel; results leave on
// res_o, and frame_last marks the result for the last pixel of a frame. The
// frame size sits in two registers written over cfg_i, which is always ready;
// write them only while the filter is idle. Each result is the 3x3 Sobel X
// response with a zero border, clamped to 0..255.
// The result for pixel (y,x) is caused by the item of pixel (y+1,x+1), so the
// host sends width+1 trailer items after each frame to flush the last row.
// Each result is computed in the memory stage and written into the output queue,
// from which it is offered. The filter accepts one item per cycle while
// pix_i.ready is high. Both line stores share one memory word per column; the
// word read for an item is written back from the memory stage, and a read of
// the column being written in that cycle is forwarded. After reset the line
// memory is cleared entry by entry while pix_i.ready stays low; the registers
// return to 640 by 480. Results wait in a three-entry output queue. When the
// receiver stalls, the filter keeps taking items until the queue and the stage
// ahead of it could no longer hold what is in flight, and then drops pix_i.ready.
module sobel_x_edge_filter #(
  parameter int MAX_WIDTH = sxe_pkg::MaxWidthDflt
) (
  input logic   clk_i,
  input logic   rst_ni,
  sxe_pix_if.sink   pix_i,
  sxe_res_if.source res_o,
  sxe_cfg_if.sink   cfg_i
);
  import sxe_pkg::*;

  localparam int AW        = $clog2(MAX_WIDTH);
  localparam int FifoDepth = 3;

  // Control that travels from the accept stage to the memory stage.
  typedef struct packed {
    logic            valid;  // item yields a result
    logic            last;   // result ends the frame
    logic            col0;   // item sits at column zero
    logic            col1;   // item sits at column one
    logic            wide;   // frame is at least two pixels wide
    logic            rge1;   // a row above exists
    logic            rge2;   // two rows above exist
    logic [PixW-1:0] pix;
  } s1_ctl_t;

  typedef struct packed {
    logic [PixW-1:0] edge_value;
    logic            frame_last;
  } res_t;

  // Configuration registers.
  logic [CfgDataW-1:0] width_q, width_d;
  logic [CfgDataW-1:0] height_q, height_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        RegFrameWidth:  width_d  = cfg_i.data;
        RegFrameHeight: height_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Accept stage: position counters and the per-item decisions.
  logic [AW-1:0]       col_q, col_d;
  logic [CfgDataW-1:0] row_q, row_d;
  logic [AW:0]         w_eff, col_next;
  logic [CfgDataW-1:0] h_eff, h_plus1;
  logic                col_zero, in_acc, clr_busy;
  s1_ctl_t             s0_ctl;

  assign in_acc   = pix_i.valid && pix_i.ready;
  assign col_zero = (col_q == '0);
  assign col_next = {1'b0, col_q} + (AW + 1)'(1);

  always_comb begin
    // Zero sizes count as one; oversize values saturate.
    if (width_q == '0) begin
      w_eff = (AW + 1)'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = (AW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = (AW + 1)'(width_q);
    end
    if (height_q == '0) begin
      h_eff = CfgDataW'(1);
    end else if (height_q > CfgDataW'(HeightCap)) begin
      h_eff = CfgDataW'(HeightCap);
    end else begin
      h_eff = height_q;
    end
    h_plus1 = h_eff + CfgDataW'(1);
  end

  always_comb begin
    s0_ctl      = '0;
    s0_ctl.col0 = col_zero;
    s0_ctl.col1 = (col_q == AW'(1));
    s0_ctl.wide = (w_eff >= (AW + 1)'(2));
    s0_ctl.rge1 = (row_q >= CfgDataW'(1));
    s0_ctl.rge2 = (row_q >= CfgDataW'(2));
    // Trailers and everything below the frame feed the bottom border.
    s0_ctl.pix  = (pix_i.trailer || row_q >= h_eff) ? '0 : pix_i.pixel_in;
    if (col_zero) begin
      // Column zero closes the previous row of two rows up.
      s0_ctl.valid = s0_ctl.rge2 && (row_q <= h_plus1);
      s0_ctl.last  = (row_q == h_plus1);
    end else begin
      s0_ctl.valid = s0_ctl.rge1 && (row_q <= h_eff);
      s0_ctl.last  = 1'b0;
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_zero && row_q >= h_plus1) begin
        col_d = '0;
        row_d = '0;
      end else if (col_next >= w_eff) begin
        col_d = '0;
        row_d = row_q + CfgDataW'(1);
      end else begin
        col_d = col_next[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Memory stage registers.
  logic          s1_valid_q;
  s1_ctl_t       s1_q;
  logic [AW-1:0] s1_addr_q;
  logic          fwd_q;
  line_word_t    fwd_data_q;
  line_word_t    mem_rd, rd_word, wr_word;
  logic          fwd_hit;

  // The item now in the memory stage writes the column the new item reads.
  assign fwd_hit = s1_valid_q && (s1_addr_q == col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      fwd_q      <= in_acc && fwd_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q       <= s0_ctl;
      s1_addr_q  <= col_q;
      fwd_data_q <= wr_word;
    end
  end

  sxe_line_mem #(
    .Depth (MAX_WIDTH)
  ) u_line_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (col_q),
    .rd_data_o  (mem_rd),
    .wr_en_i    (s1_valid_q),
    .wr_addr_i  (s1_addr_q),
    .wr_data_i  (wr_word),
    .clr_busy_o (clr_busy)
  );

  // The window is kept as column sums (top + 2*middle + bottom). The two
  // latest columns are held, oldest first; the incoming column is cs_new.
  logic [PixW+1:0]       cs1_q, cs2_q, cs_new;
  logic [PixW-1:0]       above1, above2;
  logic signed [PixW+3:0] sum;
  logic [PixW-1:0]       edge_val;

  always_comb begin
    rd_word = fwd_q ? fwd_data_q : mem_rd;
    // Rows above the top of the frame read as border.
    above2  = s1_q.rge2 ? rd_word.prev : '0;
    above1  = s1_q.rge1 ? rd_word.curr : '0;
    wr_word.prev = rd_word.curr;
    wr_word.curr = s1_q.pix;
    cs_new = (PixW + 2)'(above2) + (PixW + 2)'({above1, 1'b0}) + (PixW + 2)'(s1_q.pix);
    if (s1_q.col0) begin
      // The center is the newest held column and its right neighbor is the
      // border, so only the negated left column remains.
      sum = s1_q.wide ? -$signed({2'b00, cs1_q}) : '0;
    end else if (s1_q.col1) begin
      sum = $signed({2'b00, cs_new});
    end else begin
      sum = $signed({2'b00, cs_new}) - $signed({2'b00, cs1_q});
    end
    if (sum < 0) begin
      edge_val = '0;
    end else if (sum > (PixW + 4)'(255)) begin
      edge_val = '1;
    end else begin
      edge_val = sum[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs1_q <= '0;
      cs2_q <= '0;
    end else if (s1_valid_q) begin
      cs1_q <= cs2_q;
      cs2_q <= cs_new;
    end
  end

  // Output queue.
  res_t       fifo_mem [FifoDepth];
  logic [1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  logic [2:0] in_flight;

  assign push = s1_valid_q && s1_q.valid;
  assign pop  = res_o.valid && res_o.ready;

  assign res_o.valid      = (cnt_q != '0);
  assign res_o.edge_value = fifo_mem[rd_ptr_q].edge_value;
  assign res_o.frame_last = fifo_mem[rd_ptr_q].frame_last;

  // Room for the queue contents, the memory stage and one more item.
  assign in_flight   = 3'(cnt_q) + 3'(s1_valid_q);
  assign pix_i.ready = !clr_busy && (in_flight < 3'(FifoDepth));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == 2'(FifoDepth - 1)) ? '0 : wr_ptr_q + 2'd1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == 2'(FifoDepth - 1)) ? '0 : rd_ptr_q + 2'd1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[wr_ptr_q] <= '{edge_value: edge_val, frame_last: s1_q.last};
    end
  end

  // The queue never overflows: the ready rule leaves room for what is in flight.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (cnt_q < 2'(FifoDepth)))
    else $error("output queue overflow");

  // No item enters while the line memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_acc)
    else $error("item accepted during line memory clear");

  // The item that ends a frame leaves both counters at zero.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s0_ctl.last) |=> (col_q == '0 && row_q == '0))
    else $error("counters not cleared at frame end");

  // A forwarded read only follows a write to the same column.
  a_fwd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (s1_valid_q && $past(s1_valid_q) && s1_addr_q == $past(s1_addr_q)))
    else $error("forwarded read without a matching write");

endmodule
